// File: design/gbdf_pkg.sv
// Package for the grid distance-field block: op codes, register indexes,
// grid limits, sequencer states and distance constants. No dependencies.
package gbdf_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FILL = 2'd1,
        OP_BEST = 2'd2,
        OP_READ = 2'd3
    } op_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    localparam int DIST_W = 13;
    localparam logic [DIST_W-1:0] DIST_WALL = 13'h1FFF;
    localparam logic [DIST_W-1:0] DIST_MAX  = 13'd4095;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_REQ,
        ST_NB_WAIT,
        ST_BEST_REQ,
        ST_BEST_WAIT,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

endpackage

// File: design/gbdf_core.sv
// Sequencer and maps of the grid distance-field block.
// Uses gbdf_pkg. Wall, distance+visited and queue memories live here.
module gbdf_core
    import gbdf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [1:0]        op,
    input  logic [5:0]        tile_x,
    input  logic [5:0]        tile_y,
    input  logic              solid,
    input  logic [XW:0]       eff_w,
    input  logic [YW:0]       eff_h,
    output logic              busy,
    output logic              done,
    output logic [5:0]        res_x,
    output logic [5:0]        res_y,
    output logic [DIST_W-1:0] res_dist,
    output logic              res_found
);
    localparam int CELLS = 1 << AW;

    logic              wall_mem [CELLS];
    logic [DIST_W:0]   dist_mem [CELLS];   // {visited, distance}
    logic [AW-1:0]     queue_mem [CELLS];

    state_t state_reg, state_next;
    logic [AW:0]       ptr_reg, ptr_next;
    logic [AW:0]       head_reg, head_next, tail_reg, tail_next;
    logic [XW-1:0]     cx_reg, cx_next;
    logic [YW-1:0]     cy_reg, cy_next;
    logic [3:0]        k_reg, k_next;      // neighbour or window index
    logic [DIST_W-1:0] carry_reg, carry_next, nd_reg, nd_next;
    logic [5:0]        bx_reg, bx_next, by_reg, by_next;
    logic [DIST_W-1:0] bd_reg, bd_next;
    logic              bf_reg, bf_next;
    logic [XW-1:0]     ax_reg, ax_next;
    logic [YW-1:0]     ay_reg, ay_next;
    logic [1:0]        op_reg;
    logic [5:0]        tx_reg, ty_reg;

    logic [AW-1:0] rd_addr, q_rd_addr;
    logic          rd_en;
    logic [DIST_W:0] rd_data;
    logic          wall_rd;
    logic [AW-1:0] q_rd_data;
    logic          d_we, q_we, w_we;
    logic [AW-1:0] d_waddr, q_waddr, w_waddr;
    logic          w_wdata;
    logic [DIST_W:0] d_wdata;
    logic [AW-1:0] q_wdata;
    logic [AW-1:0] wall_raddr;

    always_ff @(posedge aclk) begin
        if (w_we) wall_mem[w_waddr] <= w_wdata;
        if (d_we) dist_mem[d_waddr] <= d_wdata;
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        rd_data   <= dist_mem[rd_addr];
        wall_rd   <= wall_mem[wall_raddr];
        q_rd_data <= queue_mem[q_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            carry_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            carry_reg <= carry_next;
            ptr_reg   <= ptr_next;
        end
        head_reg <= head_next; tail_reg <= tail_next;
        cx_reg <= cx_next; cy_reg <= cy_next; k_reg <= k_next;
        nd_reg <= nd_next; bx_reg <= bx_next; by_reg <= by_next;
        bd_reg <= bd_next; bf_reg <= bf_next;
        ax_reg <= ax_next; ay_reg <= ay_next;
        if (start) begin
            op_reg <= op; tx_reg <= tile_x; ty_reg <= tile_y;
        end
    end

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'({y, x});
    endfunction

    // neighbour candidate for the neighbour-request state
    logic          nb_ok;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    always_comb begin
        nb_ok = 1'b0; nb_x = cx_reg; nb_y = cy_reg;
        unique case (k_reg[1:0])
            2'd0: begin nb_ok = cx_reg != '0; nb_x = cx_reg - 1'b1; end
            2'd1: begin nb_ok = (XW+1)'(cx_reg) + 1'b1 < eff_w; nb_x = cx_reg + 1'b1; end
            2'd2: begin nb_ok = cy_reg != '0; nb_y = cy_reg - 1'b1; end
            default: begin nb_ok = (YW+1)'(cy_reg) + 1'b1 < eff_h; nb_y = cy_reg + 1'b1; end
        endcase
    end

    // window tile for the best-neighbour scan: k = 3*row + col
    logic [1:0] wr, wc;
    logic [XW+1:0] wxs;
    logic [YW+1:0] wys;
    logic w_ok;
    always_comb begin
        wr = (k_reg >= 4'd6) ? 2'd2 : (k_reg >= 4'd3) ? 2'd1 : 2'd0;
        wc = 2'(k_reg - 4'(wr) * 4'd3);
        wxs = (XW+2)'(tx_reg) + (XW+2)'(wc) - 1'b1;
        wys = (YW+2)'(ty_reg) + (YW+2)'(wr) - 1'b1;
        w_ok = !wxs[XW+1] && !wys[YW+1] && (wxs[XW:0] < (XW+1)'(eff_w))
               && (wys[YW:0] < (YW+1)'(eff_h));
    end

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic          s_in;
    logic [DIST_W-1:0] d_cur;
    assign sx = XW'(tx_reg);
    assign sy = YW'(ty_reg);
    assign s_in = ((XW+1)'(tx_reg) < eff_w) && ((YW+1)'(ty_reg) < eff_h)
                  && (7'(tx_reg) < 7'(MAX_WIDTH)) && (7'(ty_reg) < 7'(MAX_HEIGHT));
    assign d_cur = rd_data[DIST_W-1:0];

    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg; head_next = head_reg; tail_next = tail_reg;
        cx_next = cx_reg; cy_next = cy_reg; k_next = k_reg;
        carry_next = carry_reg; nd_next = nd_reg;
        bx_next = bx_reg; by_next = by_reg; bd_next = bd_reg; bf_next = bf_reg;
        ax_next = ax_reg; ay_next = ay_reg;
        rd_addr = addr_of(cx_reg, cy_reg); wall_raddr = rd_addr;
        q_rd_addr = head_reg[AW-1:0];
        d_we = 1'b0; d_waddr = '0; d_wdata = '0;
        q_we = 1'b0; q_waddr = tail_reg[AW-1:0]; q_wdata = '0;
        w_we = 1'b0; w_waddr = '0; w_wdata = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                // zero the wall and distance maps once after reset
                d_we = 1'b1; d_waddr = ptr_reg[AW-1:0]; d_wdata = '0;
                w_we = 1'b1; w_waddr = ptr_reg[AW-1:0];
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (AW+1)'(CELLS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (op_t'(op))
                        OP_LOAD: begin
                            w_we = (7'(tile_x) < 7'(MAX_WIDTH)) && (7'(tile_y) < 7'(MAX_HEIGHT));
                            w_waddr = AW'({tile_y[YW-1:0], tile_x[XW-1:0]});
                            w_wdata = solid;
                            state_next = ST_DONE;
                        end
                        OP_FILL: begin ptr_next = '0; state_next = ST_CLEAR; end
                        OP_BEST: begin
                            k_next = '0; bf_next = 1'b0; bd_next = '0;
                            bx_next = tile_x; by_next = tile_y;
                            state_next = ST_BEST_REQ;
                        end
                        default: begin
                            rd_addr = AW'({tile_y[YW-1:0], tile_x[XW-1:0]});
                            state_next = ST_READ_WAIT;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                if (!s_in) state_next = ST_DONE;
                else begin
                    d_we = 1'b1; d_waddr = ptr_reg[AW-1:0]; d_wdata = '0;
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == (AW+1)'(CELLS - 1)) begin
                        // mark the start tile; wall state read below after write
                        cx_next = sx; cy_next = sy;
                        head_next = '0; tail_next = '0;
                        k_next = 4'd4; // start-marking pass
                        state_next = ST_NB_REQ;
                    end
                end
            end
            ST_POP: begin
                if (head_reg == tail_reg) state_next = ST_DONE;
                else begin
                    q_rd_addr = head_reg[AW-1:0];
                    head_next = head_reg + 1'b1;
                    state_next = ST_POP_WAIT;
                    k_next = 4'd5;
                end
            end
            ST_POP_WAIT: begin
                if (k_reg == 4'd5) begin
                    cx_next = q_rd_data[XW-1:0];
                    cy_next = q_rd_data[AW-1:XW];
                    rd_addr = q_rd_data;
                    k_next = 4'd6;
                end else begin
                    if (d_cur != DIST_WALL) begin
                        carry_next = d_cur;
                        nd_next = (d_cur >= DIST_MAX) ? DIST_MAX : d_cur + 1'b1;
                    end else
                        nd_next = (carry_reg >= DIST_MAX) ? DIST_MAX : carry_reg + 1'b1;
                    k_next = '0;
                    state_next = ST_NB_REQ;
                end
            end
            ST_NB_REQ: begin
                // k 0..3 neighbours, k 4 start tile
                if (k_reg == 4'd4) begin
                    ax_next = cx_reg; ay_next = cy_reg;
                    rd_addr = addr_of(cx_reg, cy_reg); wall_raddr = rd_addr;
                    nd_next = '0;
                    state_next = ST_NB_WAIT;
                end else if (nb_ok) begin
                    ax_next = nb_x; ay_next = nb_y;
                    rd_addr = addr_of(nb_x, nb_y); wall_raddr = rd_addr;
                    state_next = ST_NB_WAIT;
                end else if (k_reg == 4'd3) state_next = ST_POP;
                else k_next = k_reg + 1'b1;
            end
            ST_NB_WAIT: begin
                if (!rd_data[DIST_W]) begin
                    d_we = 1'b1; d_waddr = addr_of(ax_reg, ay_reg);
                    d_wdata = {1'b1, wall_rd ? DIST_WALL : nd_reg};
                    q_we = tail_reg < (AW+1)'(CELLS);
                    q_wdata = d_waddr;
                    if (q_we) tail_next = tail_reg + 1'b1;
                end
                if (k_reg >= 4'd3) state_next = ST_POP;
                else begin k_next = k_reg + 1'b1; state_next = ST_NB_REQ; end
            end
            ST_BEST_REQ: begin
                if (w_ok) begin
                    ax_next = wxs[XW-1:0]; ay_next = wys[YW-1:0];
                    rd_addr = addr_of(wxs[XW-1:0], wys[YW-1:0]);
                    state_next = ST_BEST_WAIT;
                end else if (k_reg == 4'd8)
                    state_next = ST_DONE;
                else k_next = k_reg + 1'b1;
            end
            ST_BEST_WAIT: begin
                if (!d_cur[DIST_W-1] && (!bf_reg || d_cur < bd_reg)) begin
                    bf_next = 1'b1; bd_next = d_cur;
                    bx_next = 6'(ax_reg); by_next = 6'(ay_reg);
                end
                if (k_reg == 4'd8)
                    state_next = ST_DONE;
                else begin k_next = k_reg + 1'b1; state_next = ST_BEST_REQ; end
            end
            ST_READ_WAIT: begin
                bd_next = s_in ? d_cur : '0;
                state_next = ST_DONE;
            end
            default: begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    always_comb begin
        res_x = tx_reg; res_y = ty_reg; res_dist = '0; res_found = 1'b1;
        if (op_reg == OP_BEST) begin
            res_found = bf_reg;
            if (bf_reg) begin res_x = bx_reg; res_y = by_reg; res_dist = bd_reg; end
        end else if (op_reg == OP_READ) res_dist = bd_reg;
    end
endmodule

// File: design/grid_bfs_distance_field.sv
// Top level of the grid distance-field block: stream ports, config
// registers and output register. Uses gbdf_pkg and gbdf_core.
//
//  channel   dir  payload
//  s_axis    in   tdata: op[1:0] tile_x[7:2] tile_y[13:8] solid[14]
//  m_axis    out  tdata: best_x[5:0] best_y[11:6] distance[24:12] found[25]
//  cfg       in   cfg_index (0 width, 1 height), cfg_data[6:0]
//
// One item at a time. A best-neighbour query scans 9 window slots and reads
// the distance map only for slots inside the grid. A fill whose start tile
// lies inside the grid first clears all 4096 cells of the distance map,
// then visits each reached tile in turn (one port on the distance map).
// Synchronous active-low reset, then a pass over all 4096 cells zeroes the wall
// and distance maps with s_axis_tready low.
// A stalled result is held in the output register; the next item is taken
// as soon as that register is free.
module grid_bfs_distance_field
    import gbdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op, tile_x, tile_y, solid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // best_x, best_y, distance, found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    logic [6:0] w_reg, h_reg;
    logic [XW:0] eff_w;
    logic [YW:0] eff_h;
    logic busy, done, start, mv_reg;
    logic [5:0] rx, ry;
    logic [DIST_W-1:0] rd;
    logic rf;
    logic [25:0] out_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= 7'd64; h_reg <= 7'd64; mv_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_WIDTH) w_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_HEIGHT) h_reg <= cfg_data;
            if (done) mv_reg <= 1'b1;
            else if (m_axis_tready) mv_reg <= 1'b0;
        end
        if (done) out_reg <= {rf, rd, ry, rx};
    end

    assign eff_w = (w_reg == '0) ? (XW+1)'(1) :
                   (32'(w_reg) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(w_reg);
    assign eff_h = (h_reg == '0) ? (YW+1)'(1) :
                   (32'(h_reg) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(h_reg);

    assign s_axis_tready = !busy && !mv_reg;
    assign start = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata = {6'd0, out_reg};

    gbdf_core u_core (
        .aclk, .aresetn, .start,
        .op(s_axis_tdata[1:0]), .tile_x(s_axis_tdata[7:2]),
        .tile_y(s_axis_tdata[13:8]), .solid(s_axis_tdata[14]),
        .eff_w, .eff_h, .busy, .done,
        .res_x(rx), .res_y(ry), .res_dist(rd), .res_found(rf)
    );
endmodule
